// ----- hdl/srichk_pkg.sv -----
// ----------------------------------------------------------------------------
// srichk_pkg
// Shared types, constants and the byte-wide CRC-32 step for the stored
// record integrity checker.
// ----------------------------------------------------------------------------
package srichk_pkg;

  // Header layout, in bytes from the start of the record.
  localparam int unsigned HeaderBytes  = 24;
  localparam int unsigned SchemaPos    = 4;
  localparam int unsigned ReservedPos  = 6;
  localparam int unsigned GenPos       = 8;
  localparam int unsigned LenPos       = 16;
  localparam int unsigned CrcPos       = 20;

  // Magic "DDST" as it lands little-endian, byte 0 in the low bits.
  localparam logic [31:0] Magic        = 32'h5453_4444;

  // Reflected CRC-32, IEEE polynomial.
  localparam logic [31:0] CrcPoly      = 32'hEDB8_8320;
  localparam logic [31:0] CrcPreset    = 32'hFFFF_FFFF;

  // Byte counter width and saturation value.
  localparam int unsigned CountW       = 17;
  localparam logic [CountW-1:0] CountMax = '1;

  // Register reset values.
  localparam logic [15:0] MaxRecordReset = 16'd4096;
  localparam logic [15:0] CurSchemaReset = 16'd2;

  // Configuration register indexes.
  typedef enum logic {
    REG_MAX_RECORD = 1'b0,
    REG_CUR_SCHEMA = 1'b1
  } reg_idx_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_CURRENT_OK = 3'd0,
    STAT_LEGACY_OK  = 3'd1,
    STAT_FUTURE_OK  = 3'd2,
    STAT_BAD_LEN    = 3'd3,
    STAT_BAD_MAGIC  = 3'd4,
    STAT_BAD_HEADER = 3'd5,
    STAT_CRC_BAD    = 3'd6
  } status_t;

  // One byte through the reflected CRC-32, eight shift steps unrolled.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/storage_record_integrity_check_core.sv -----
// ----------------------------------------------------------------------------
// storage_record_integrity_check_core
// Checks one stored record per frame: header fields, length and CRC-32.
// ----------------------------------------------------------------------------
// The block takes one record byte per word on the slave side, with tlast on
// the final byte, and gives one result word per record on the master side.
// It accepts a byte in every cycle. A byte goes through an input register,
// where the header capture and both byte-wide CRC-32 updates happen. On the
// final byte the status is decided from the finished record and goes
// straight into the output register, and the next record may start right
// behind it. The input stalls only when a final byte sits in the input
// register and the output word ahead of it is not taken. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must write it only
// while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module storage_record_integrity_check_core
  import srichk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // Configuration write port.
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data,
  // Record bytes.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,   // last_byte
  // Results.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // [2:0] status, [66:3] generation,
                                  // [82:67] schema_version,
                                  // [98:83] payload_length, [103:99] zero
);

  localparam int unsigned LenW = CountW + 1;

  // Configuration registers.
  logic [15:0] max_record_bytes;
  logic [15:0] current_schema;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_bytes <= MaxRecordReset;
      current_schema   <= CurSchemaReset;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MAX_RECORD: max_record_bytes <= cfg_data;
        REG_CUR_SCHEMA: current_schema   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshakes.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_ok;
  logic       in_adv;

  assign out_ok   = !m_tvalid || m_tready;
  assign in_adv   = in_valid && (!in_last || out_ok);
  assign s_tready = !in_valid || in_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= (s_tvalid && s_tready) || (in_valid && !in_adv);
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Record accumulators.
  logic [CountW-1:0] byte_count;
  logic              magic_ok;
  logic [31:0]       header_payload_crc;
  logic [31:0]       payload_only_crc;
  logic [15:0]       schema_field;
  logic [15:0]       reserved_field;
  logic [63:0]       generation_field;
  logic [31:0]       length_field;
  logic [31:0]       stored_crc_field;

  logic              magic_ok_next;
  logic [31:0]       header_payload_crc_next;
  logic [31:0]       payload_only_crc_next;
  logic [15:0]       schema_field_next;
  logic [15:0]       reserved_field_next;
  logic [63:0]       generation_field_next;
  logic [31:0]       length_field_next;
  logic [31:0]       stored_crc_field_next;
  logic              in_payload;
  logic              in_protected;

  // Header capture and CRC update for the byte in the input register.
  always_comb begin
    magic_ok_next           = magic_ok;
    schema_field_next       = schema_field;
    reserved_field_next     = reserved_field;
    generation_field_next   = generation_field;
    length_field_next       = length_field;
    stored_crc_field_next   = stored_crc_field;
    in_payload   = byte_count >= CountW'(HeaderBytes);
    in_protected = (byte_count >= CountW'(SchemaPos)) && (byte_count < CountW'(CrcPos));

    if (byte_count < CountW'(SchemaPos)) begin
      if (in_byte != Magic[8*byte_count[1:0] +: 8]) magic_ok_next = 1'b0;
    end else if (byte_count < CountW'(ReservedPos)) begin
      schema_field_next[8*byte_count[0] +: 8] = in_byte;
    end else if (byte_count < CountW'(GenPos)) begin
      reserved_field_next[8*byte_count[0] +: 8] = in_byte;
    end else if (byte_count < CountW'(LenPos)) begin
      generation_field_next[8*byte_count[2:0] +: 8] = in_byte;
    end else if (byte_count < CountW'(CrcPos)) begin
      length_field_next[8*byte_count[1:0] +: 8] = in_byte;
    end else if (byte_count < CountW'(HeaderBytes)) begin
      stored_crc_field_next[8*byte_count[1:0] +: 8] = in_byte;
    end

    header_payload_crc_next = (in_protected || in_payload) ?
                              crc32_byte(header_payload_crc, in_byte) : header_payload_crc;
    payload_only_crc_next   = in_payload ?
                              crc32_byte(payload_only_crc, in_byte) : payload_only_crc;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_adv && in_last)) begin
      byte_count         <= '0;
      magic_ok           <= 1'b1;
      header_payload_crc <= CrcPreset;
      payload_only_crc   <= CrcPreset;
      schema_field       <= '0;
      reserved_field     <= '0;
      generation_field   <= '0;
      length_field       <= '0;
      stored_crc_field   <= '0;
    end else if (in_adv) begin
      if (byte_count != CountMax) byte_count <= byte_count + 1'b1;
      magic_ok           <= magic_ok_next;
      header_payload_crc <= header_payload_crc_next;
      payload_only_crc   <= payload_only_crc_next;
      schema_field       <= schema_field_next;
      reserved_field     <= reserved_field_next;
      generation_field   <= generation_field_next;
      length_field       <= length_field_next;
      stored_crc_field   <= stored_crc_field_next;
    end
  end

  // Status decision on the final byte, first failing check wins.
  logic [LenW-1:0] rec_len;
  logic            len_short;
  logic [LenW-1:0] payload;
  logic            hp_match;
  logic            po_match;
  status_t         status_next;
  logic [15:0]     payload_out;
  logic [63:0]     gen_out;

  always_comb begin
    rec_len   = {1'b0, byte_count} + 1'b1;
    len_short = rec_len < LenW'(HeaderBytes);
    payload   = len_short ? '0 : rec_len - LenW'(HeaderBytes);
    hp_match  = ~header_payload_crc_next == stored_crc_field_next;
    po_match  = ~payload_only_crc_next == stored_crc_field_next;

    if (len_short || (rec_len > {{(LenW-16){1'b0}}, max_record_bytes})) begin
      status_next = STAT_BAD_LEN;
    end else if (!magic_ok_next) begin
      status_next = STAT_BAD_MAGIC;
    end else if ((reserved_field_next != '0) || (generation_field_next == '0) ||
                 (length_field_next != {{(32-LenW){1'b0}}, payload})) begin
      status_next = STAT_BAD_HEADER;
    end else if (schema_field_next == 16'd1) begin
      status_next = po_match ? STAT_LEGACY_OK : STAT_CRC_BAD;
    end else if (schema_field_next == current_schema) begin
      status_next = hp_match ? STAT_CURRENT_OK : STAT_CRC_BAD;
    end else if (schema_field_next > current_schema) begin
      status_next = hp_match ? STAT_FUTURE_OK : STAT_CRC_BAD;
    end else begin
      status_next = STAT_BAD_HEADER;
    end

    payload_out = (payload[LenW-1:16] != '0) ? 16'hFFFF : payload[15:0];
    gen_out     = len_short ? '0 : generation_field_next;
  end

  // Output register.
  status_t     status;
  logic [63:0] generation;
  logic [15:0] schema_version;
  logic [15:0] payload_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ok) begin
      m_tvalid <= in_valid && in_last;
    end
    if (in_adv && in_last) begin
      status         <= status_next;
      generation     <= gen_out;
      schema_version <= schema_field_next;
      payload_length <= payload_out;
    end
  end

  assign m_tdata = {5'd0, payload_length, schema_version, generation, status};

  // A new result only ever comes out of a final byte.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (out_ok && !(in_valid && in_last)) |=> !m_tvalid)
    else $error("result word appeared with no final byte behind it");

  // The input only stalls behind a final byte that cannot move on.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && in_last && !out_ok))
    else $error("input stalled with room downstream");

  // A passing record always carries a nonzero generation.
  a_ok_has_gen: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (status == STAT_CURRENT_OK || status == STAT_LEGACY_OK ||
                  status == STAT_FUTURE_OK)) |-> (generation != '0))
    else $error("passing record reported with zero generation");

  // A closed record leaves the accumulators at their start values.
  a_record_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_adv && in_last) |=> (byte_count == '0 && magic_ok))
    else $error("record state not cleared after final byte");

endmodule

// ----- sim/tb_storage_record_integrity_check_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_storage_record_integrity_check_core
// The testbench streams stored records into the checker one byte per word. It
// starts with a short table of hand-built records, then sends random records,
// most of them well formed, across several register settings and idle
// patterns. A local model of the header capture and of both CRC-32 values
// predicts every result word, and each result word is compared field by field.
// ----------------------------------------------------------------------------
module tb_storage_record_integrity_check_core;
  import srichk_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned SendIdleA   = 31;
  localparam int unsigned RecvIdleA   = 57;
  localparam int unsigned PlanRows    = 18;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned PhaseRecs   = 1;
  localparam int unsigned DrainCycles = 8;

  // Ways in which a generated record departs from a well-formed one.
  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_RESERVED,
    FLAW_GEN_ZERO,
    FLAW_LEN_FIELD,
    FLAW_CRC,
    FLAW_CUT,
    FLAW_NOISE
  } flaw_t;

  // One result word, laid out as on m_tdata.
  typedef struct packed {
    logic [15:0] plen;
    logic [15:0] schema;
    logic [63:0] gen;
    status_t     status;
  } verdict_t;

  // One row of the directed table. For a cut or noise record, plen is the
  // whole record length instead of the payload length.
  typedef struct {
    logic [15:0] schema;
    logic [63:0] gen;
    int unsigned plen;
    flaw_t       flaw;
    bit          pinned;
    status_t     want;
  } plan_row_t;

  typedef struct {
    int unsigned max_bytes;
    int unsigned cur;
    int unsigned send_idle;
    int unsigned recv_idle;
  } phase_t;

  plan_row_t plan_rows [PlanRows] = '{
    '{16'd2,     64'd1,                  0,      FLAW_NONE,      1'b1, STAT_CURRENT_OK},
    '{16'd2,     64'hFFFF_FFFF_FFFF_FFFF, 5,     FLAW_NONE,      1'b0, STAT_CURRENT_OK},
    '{16'd1,     64'h0123_4567_89AB_CDEF, 10,    FLAW_NONE,      1'b0, STAT_CURRENT_OK},
    '{16'd1,     64'h8000_0000_0000_0000, 0,     FLAW_NONE,      1'b0, STAT_CURRENT_OK},
    '{16'd3,     64'd2,                  4,      FLAW_NONE,      1'b0, STAT_CURRENT_OK},
    '{16'hFFFF,  64'hFEDC_BA98_7654_3210, 8,     FLAW_NONE,      1'b0, STAT_CURRENT_OK},
    '{16'd0,     64'd5,                  3,      FLAW_NONE,      1'b1, STAT_BAD_HEADER},
    '{16'd2,     64'd9,                  6,      FLAW_CRC,       1'b1, STAT_CRC_BAD},
    '{16'd1,     64'd9,                  6,      FLAW_CRC,       1'b1, STAT_CRC_BAD},
    '{16'd9,     64'd9,                  6,      FLAW_CRC,       1'b1, STAT_CRC_BAD},
    '{16'd2,     64'd3,                  2,      FLAW_MAGIC,     1'b1, STAT_BAD_MAGIC},
    '{16'd2,     64'd3,                  2,      FLAW_RESERVED,  1'b1, STAT_BAD_HEADER},
    '{16'd2,     64'd3,                  2,      FLAW_GEN_ZERO,  1'b1, STAT_BAD_HEADER},
    '{16'd2,     64'd3,                  2,      FLAW_LEN_FIELD, 1'b1, STAT_BAD_HEADER},
    '{16'd2,     64'd3,                  23,     FLAW_CUT,       1'b1, STAT_BAD_LEN},
    '{16'd2,     64'd3,                  1,      FLAW_CUT,       1'b1, STAT_BAD_LEN},
    '{16'd2,     64'd4,                  1,      FLAW_NONE,      1'b0, STAT_CURRENT_OK},
    '{16'd0,     64'd0,                  28,     FLAW_NOISE,     1'b0, STAT_CURRENT_OK}
  };

  phase_t phases [PhaseCount] = '{
    '{65535, 2,     SendIdleA, RecvIdleA},
    '{24,    65535, SendIdleA, RecvIdleA},
    '{200,   3,     RecvIdleA, SendIdleA},
    '{4096,  1,     RecvIdleA, SendIdleA},
    '{100,   40000, 0,         0},
    '{4096,  2,     0,         0}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_index = REG_MAX_RECORD;
  logic [15:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;

  int unsigned send_idle_pct = SendIdleA;
  int unsigned recv_idle_pct = RecvIdleA;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;

  // Register shadows and the record state of the local model.
  logic [15:0]       lim_bytes = MaxRecordReset;
  logic [15:0]       cur_schema = CurSchemaReset;
  logic [CountW-1:0] rec_pos;
  logic              magic_good;
  logic [31:0]       crc_hdr;
  logic [31:0]       crc_pay;
  logic [15:0]       f_schema;
  logic [15:0]       f_resv;
  logic [63:0]       f_gen;
  logic [31:0]       f_len;
  logic [31:0]       f_crc;

  verdict_t   pending_verdicts [$];
  logic [7:0] rec_bytes [$];

  storage_record_integrity_check_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    err_count++;
  endtask

  // Reflected CRC-32, one data bit fed in per shift.
  function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r = {1'b0, r[31:1]} ^ (fb ? CrcPoly : 32'h0);
    end
    return r;
  endfunction

  task automatic open_record();
    rec_pos    = '0;
    magic_good = 1'b1;
    crc_hdr    = CrcPreset;
    crc_pay    = CrcPreset;
    f_schema   = '0;
    f_resv     = '0;
    f_gen      = '0;
    f_len      = '0;
    f_crc      = '0;
  endtask

  // Takes one accepted byte into the model; on the final byte it decides the
  // result word and starts a new record.
  task automatic absorb_byte(input logic [7:0] b, input logic fin,
                             output bit has_res, output verdict_t v);
    int unsigned p;
    int unsigned len;
    int unsigned pay;
    p = rec_pos;
    if (p < 4) begin
      if (b != Magic[8*p +: 8]) magic_good = 1'b0;
    end else if (p < 6) begin
      f_schema[8*(p-4) +: 8] = b;
    end else if (p < 8) begin
      f_resv[8*(p-6) +: 8] = b;
    end else if (p < 16) begin
      f_gen[8*(p-8) +: 8] = b;
    end else if (p < 20) begin
      f_len[8*(p-16) +: 8] = b;
    end else if (p < HeaderBytes) begin
      f_crc[8*(p-20) +: 8] = b;
    end
    if ((p >= 4 && p < 20) || p >= HeaderBytes) crc_hdr = crc_fold(crc_hdr, b);
    if (p >= HeaderBytes) crc_pay = crc_fold(crc_pay, b);
    if (rec_pos != CountMax) rec_pos++;
    has_res = fin;
    v = '0;
    if (!fin) return;

    len = p + 1;
    pay = (len >= HeaderBytes) ? len - HeaderBytes : 0;
    // The first failing check decides the status.
    if (len < HeaderBytes || len > lim_bytes) begin
      v.status = STAT_BAD_LEN;
    end else if (!magic_good) begin
      v.status = STAT_BAD_MAGIC;
    end else if (f_resv != 0 || f_gen == 0 || f_len != pay) begin
      v.status = STAT_BAD_HEADER;
    end else if (f_schema == 16'd1) begin
      v.status = (~crc_pay == f_crc) ? STAT_LEGACY_OK : STAT_CRC_BAD;
    end else if (f_schema == cur_schema) begin
      v.status = (~crc_hdr == f_crc) ? STAT_CURRENT_OK : STAT_CRC_BAD;
    end else if (f_schema > cur_schema) begin
      v.status = (~crc_hdr == f_crc) ? STAT_FUTURE_OK : STAT_CRC_BAD;
    end else begin
      v.status = STAT_BAD_HEADER;
    end
    v.gen    = (len >= HeaderBytes) ? f_gen : 64'h0;
    v.schema = f_schema;
    v.plen   = (pay > 65535) ? 16'hFFFF : pay[15:0];
    open_record();
  endtask

  // Builds one record into rec_bytes, with a matching stored CRC unless a
  // flaw says otherwise.
  task automatic build_record(input logic [15:0] schema, input logic [63:0] gen,
                              input int unsigned plen, input flaw_t flaw);
    logic [7:0]  pay [$];
    logic [7:0]  b;
    logic [31:0] hcrc;
    logic [31:0] pcrc;
    logic [31:0] stored;
    logic [31:0] lfield;
    logic [15:0] resv;
    logic [63:0] g;
    int unsigned body;
    int unsigned k;
    rec_bytes.delete();
    if (flaw == FLAW_NOISE) begin
      repeat (plen) rec_bytes.insert(rec_bytes.size(), 8'($urandom));
      return;
    end
    body = (flaw == FLAW_CUT) ? 0 : plen;
    resv = (flaw == FLAW_RESERVED) ? 16'($urandom_range(1, 65535)) : 16'h0;
    g = (flaw == FLAW_GEN_ZERO) ? 64'h0 : gen;
    lfield = body;
    if (flaw == FLAW_LEN_FIELD) begin
      if ($urandom_range(1) == 1) lfield = $urandom;
      else lfield = lfield ^ (32'h1 << $urandom_range(31));
      if (lfield == body) lfield = lfield ^ 32'h1;
    end
    for (int i = 0; i < 4; i++) rec_bytes.insert(rec_bytes.size(), Magic[8*i +: 8]);
    for (int i = 0; i < 2; i++) rec_bytes.insert(rec_bytes.size(), schema[8*i +: 8]);
    for (int i = 0; i < 2; i++) rec_bytes.insert(rec_bytes.size(), resv[8*i +: 8]);
    for (int i = 0; i < 8; i++) rec_bytes.insert(rec_bytes.size(), g[8*i +: 8]);
    for (int i = 0; i < 4; i++) rec_bytes.insert(rec_bytes.size(), lfield[8*i +: 8]);

    // Protected header bytes first, then the payload through both CRCs.
    hcrc = CrcPreset;
    for (int i = SchemaPos; i < CrcPos; i++) hcrc = crc_fold(hcrc, rec_bytes[i]);
    pcrc = CrcPreset;
    repeat (body) begin
      b = 8'($urandom);
      pay.insert(pay.size(), b);
      hcrc = crc_fold(hcrc, b);
      pcrc = crc_fold(pcrc, b);
    end
    stored = (schema == 16'd1) ? ~pcrc : ~hcrc;
    if (flaw == FLAW_CRC) stored = stored ^ (32'h1 << $urandom_range(31));
    for (int i = 0; i < 4; i++) rec_bytes.insert(rec_bytes.size(), stored[8*i +: 8]);
    foreach (pay[i]) rec_bytes.insert(rec_bytes.size(), pay[i]);

    if (flaw == FLAW_MAGIC) begin
      k = $urandom_range(3);
      rec_bytes[k] = rec_bytes[k] ^ (8'h1 << $urandom_range(7));
    end
    if (flaw == FLAW_CUT) begin
      while (rec_bytes.size() > plen) void'(rec_bytes.pop_back());
    end
  endtask

  // Offers one byte at the current falling edge and returns once it is taken.
  // Called at a falling edge, returns at a falling edge.
  task automatic push_byte(input logic [7:0] b, input logic fin,
                           output bit has_res, output verdict_t v);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_byte(b, fin, has_res, v);
    @(negedge clk);
  endtask

  // Sends rec_bytes; a pinned status replaces the predicted one.
  task automatic send_record(input bit pinned, input status_t want);
    bit       has_res;
    verdict_t v;
    foreach (rec_bytes[i]) begin
      push_byte(rec_bytes[i], i == rec_bytes.size() - 1, has_res, v);
      if (has_res) begin
        if (pinned) v.status = want;
        pending_verdicts.insert(pending_verdicts.size(), v);
      end
    end
  endtask

  // Waits for every pending result word, then for the pipeline to settle.
  task automatic drain();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] max_bytes, input logic [15:0] cur);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAX_RECORD;
    cfg_data  <= max_bytes;
    @(negedge clk);
    cfg_index <= REG_CUR_SCHEMA;
    cfg_data  <= cur;
    @(negedge clk);
    cfg_we <= 1'b0;
    lim_bytes  = max_bytes;
    cur_schema = cur;
  endtask

  // Random records: mostly well formed with random content, lengths often
  // near the configured maximum, plus damaged records and noise.
  task automatic run_random_records(input int unsigned n);
    logic [15:0] schema;
    logic [63:0] gen;
    int unsigned plen;
    int unsigned roll;
    int          room;
    int          t;
    flaw_t       flaw;
    for (int r = 0; r < n; r++) begin
      room = int'(lim_bytes) - int'(HeaderBytes);
      roll = $urandom_range(99);
      if (roll < 15 && room <= 400) begin
        t = room + int'($urandom_range(2)) - 1;
        plen = (t < 0) ? 0 : t;
      end else if (roll < 75) begin
        plen = $urandom_range(16);
      end else begin
        plen = $urandom_range(17, 64);
      end

      roll = $urandom_range(99);
      if (roll < 30) schema = cur_schema;
      else if (roll < 50) schema = 16'd1;
      else if (roll < 70) schema = (cur_schema < 16'hFFFF) ?
                                   16'($urandom_range(cur_schema + 1, 65535)) : cur_schema;
      else if (roll < 80) schema = 16'($urandom);
      else if (roll < 90) schema = (cur_schema > 2) ?
                                   16'($urandom_range(2, cur_schema - 1)) : 16'd0;
      else schema = 16'd0;

      if ($urandom_range(99) < 60) flaw = FLAW_NONE;
      else flaw = flaw_t'($urandom_range(FLAW_MAGIC, FLAW_NOISE));
      if (flaw == FLAW_CUT) plen = $urandom_range(1, HeaderBytes - 1);
      if (flaw == FLAW_NOISE) plen = $urandom_range(1, 60);

      gen = {$urandom, $urandom};
      if (gen == 0) gen = 64'h1;
      build_record(schema, gen, plen, flaw);
      send_record(1'b0, STAT_CURRENT_OK);
    end
  endtask

  // The receiver drops ready at random, at the falling edge.
  always @(negedge clk) begin
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker: each word against the oldest prediction.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = verdict_t'(m_tdata[98:0]);
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result word with none expected, status %0d", got.status));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status: got %0d, expected %0d",
                                    got.status, want.status));
        if (got.gen !== want.gen)
          report_mismatch($sformatf("generation: got 0x%0h, expected 0x%0h",
                                    got.gen, want.gen));
        if (got.schema !== want.schema)
          report_mismatch($sformatf("schema_version: got %0d, expected %0d",
                                    got.schema, want.schema));
        if (got.plen !== want.plen)
          report_mismatch($sformatf("payload_length: got %0d, expected %0d",
                                    got.plen, want.plen));
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    open_record();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed records under the reset register values.
    for (int r = 0; r < PlanRows; r++) begin
      build_record(plan_rows[r].schema, plan_rows[r].gen, plan_rows[r].plen,
                   plan_rows[r].flaw);
      send_record(plan_rows[r].pinned, plan_rows[r].want);
    end

    // Random phases, each with its own register setting and idle pattern.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      s_tvalid <= 1'b0;
      drain();
      program_regs(16'(phases[ph].max_bytes), 16'(phases[ph].cur));
      send_idle_pct = phases[ph].send_idle;
      recv_idle_pct = phases[ph].recv_idle;
      run_random_records(PhaseRecs);
    end

    s_tvalid <= 1'b0;
    drain();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/srichk_pkg.sv
hdl/storage_record_integrity_check_core.sv
sim/tb_storage_record_integrity_check_core.sv
